// ----- rtl/jkv_pkg.sv -----
// Shared types, constants and character helpers for the JSON key/value extractor.
// Used by jkv_front, jkv_fifo, jkv_back and json_key_value_extractor; no dependencies.
package jkv_pkg;

   // Parameter defaults
   localparam int KEY_MAX_DEF     = 32;
   localparam int VALUE_MAX_DEF   = 1024;
   localparam int QUEUE_DEPTH_DEF = 4;

   // Register file layout
   localparam int KEY_REG_W   = 6;
   localparam int LIMIT_W     = 11;
   localparam int KEY_WORDS   = 4;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LENGTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_BYTES_0 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_BYTES_1 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_BYTES_2 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_BYTES_3 = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_VALUE_LIMIT = 3'd5;

   localparam logic [KEY_REG_W-1:0] KEY_LENGTH_RST  = 6'd1;
   localparam logic [LIMIT_W-1:0]   VALUE_LIMIT_RST = 11'd1024;

   // Outcome codes
   localparam logic [2:0] OC_FOUND   = 3'd0;
   localparam logic [2:0] OC_NOKEY   = 3'd1;
   localparam logic [2:0] OC_NOCOLON = 3'd2;
   localparam logic [2:0] OC_NOQUOTE = 3'd3;
   localparam logic [2:0] OC_TOOLONG = 3'd4;
   localparam logic [2:0] OC_UNSUP   = 3'd5;

   // Value kinds
   localparam logic [1:0] KIND_STRING = 2'd0;
   localparam logic [1:0] KIND_NUMBER = 2'd1;
   localparam logic [1:0] KIND_BOOL   = 2'd2;

   // Characters
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_LOW_E = 8'h65;
   localparam logic [7:0] CH_UP_E  = 8'h45;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [31:0] LIT_TRUE  = "true";
   localparam logic [39:0] LIT_FALSE = "false";
   localparam logic [2:0]  LIT_TRUE_LEN  = 3'd4;
   localparam logic [2:0]  LIT_FALSE_LEN = 3'd5;

   typedef enum logic [2:0] {
      PH_KEY,
      PH_COLON,
      PH_SPACE,
      PH_STRING,
      PH_NUMBER,
      PH_LITERAL,
      PH_DONE
   } phase_type;

   // One queue entry: the results caused by one document byte
   typedef struct packed {
      logic       emit;
      logic [7:0] value_byte;
      logic [1:0] kind;
      logic       last;
      logic [2:0] outcome;
      logic [1:0] status_kind;
   } event_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_num_char(input logic [7:0] c);
      return is_digit(c) || c == CH_DOT || c == CH_LOW_E || c == CH_UP_E || c == CH_MINUS;
   endfunction

   function automatic logic [7:0] lit_char(input logic is_false, input logic [2:0] idx);
      logic [7:0] ch;
      ch = 8'h00;
      if (is_false) begin
         if (idx < LIT_FALSE_LEN) begin
            ch = LIT_FALSE[8*(4-idx) +: 8];
         end
      end else begin
         if (idx < LIT_TRUE_LEN) begin
            ch = LIT_TRUE[8*(3-idx) +: 8];
         end
      end
      return ch;
   endfunction

endpackage

// ----- rtl/jkv_front.sv -----
// Front end: register file, key window compare and value classifier.
// Produces one queue entry per document byte that causes results; uses jkv_pkg.
module jkv_front #(
   parameter int KEY_MAX   = jkv_pkg::KEY_MAX_DEF,
   parameter int VALUE_MAX = jkv_pkg::VALUE_MAX_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_doc_byte,
   input  logic                                req_doc_end,
   input  logic                                csr_write,
   input  logic [jkv_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [jkv_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                queue_full,
   output logic                                push,
   output jkv_pkg::event_type                  push_event
);

   localparam int LEN_W = $clog2(KEY_MAX + 1);
   localparam int CNT_W = $clog2(VALUE_MAX + 1);
   localparam int PAT_W = 8 * (KEY_MAX + 1);

   // Register file
   logic [jkv_pkg::KEY_REG_W-1:0]  key_length_ff;
   logic [jkv_pkg::CSR_DATA_W-1:0] key_bytes_ff [jkv_pkg::KEY_WORDS];
   logic [jkv_pkg::LIMIT_W-1:0]    value_limit_ff;
   logic                           settle_ff;

   // Key pattern aligned to the window
   logic [jkv_pkg::KEY_WORDS*jkv_pkg::CSR_DATA_W-1:0] key_flat;
   logic [PAT_W-1:0]               pat_rev;
   logic [LEN_W-1:0]               len_eff;
   logic [LEN_W-1:0]               shamt;
   logic [PAT_W-1:0]               exp_in;
   logic [PAT_W-1:0]               exp_ff;

   // Document state
   logic [7:0]                     win_ff [KEY_MAX + 1];
   logic [7:0]                     win_in [KEY_MAX + 1];
   jkv_pkg::phase_type             phase_ff, phase_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic [2:0]                     lit_idx_ff, lit_idx_in;
   logic                           lit_false_ff, lit_false_in;
   logic [2:0]                     pending_ff, pending_in;
   logic [1:0]                     kind_ff, kind_in;

   logic                           accept;
   logic [7:0]                     c;
   logic [CNT_W-1:0]               lim;
   logic                           room;
   logic                           key_hit;
   logic [2:0]                     lit_len;
   logic                           lit_ok;
   logic                           lit_last;
   logic                           emit;

   assign accept    = req_valid && !req_stall;
   assign req_stall = queue_full || settle_ff;
   assign c         = req_doc_byte;

   // Clamp registers into their working ranges
   always_comb begin
      if (key_length_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (key_length_ff > jkv_pkg::KEY_REG_W'(KEY_MAX)) begin
         len_eff = LEN_W'(KEY_MAX);
      end else begin
         len_eff = LEN_W'(key_length_ff);
      end
      if (value_limit_ff == '0) begin
         lim = CNT_W'(1);
      end else if (value_limit_ff > jkv_pkg::LIMIT_W'(VALUE_MAX)) begin
         lim = CNT_W'(VALUE_MAX);
      end else begin
         lim = CNT_W'(value_limit_ff);
      end
   end

   // Byte u of exp_ff is what window slot u must hold for a hit (slot u <= key length)
   always_comb begin
      for (int w = 0; w < jkv_pkg::KEY_WORDS; w++) begin
         key_flat[jkv_pkg::CSR_DATA_W*w +: jkv_pkg::CSR_DATA_W] = key_bytes_ff[w];
      end
      for (int t = 0; t < KEY_MAX; t++) begin
         pat_rev[8*t +: 8] = key_flat[8*(KEY_MAX-1-t) +: 8];
      end
      pat_rev[8*KEY_MAX +: 8] = jkv_pkg::CH_QUOTE;
      shamt  = LEN_W'(KEY_MAX) - len_eff;
      exp_in = pat_rev >> {shamt, 3'b000};
   end

   always_comb begin
      key_hit = (c == jkv_pkg::CH_QUOTE);
      for (int u = 0; u <= KEY_MAX; u++) begin
         if (LEN_W'(u) <= len_eff && win_ff[u] != exp_ff[8*u +: 8]) begin
            key_hit = 1'b0;
         end
      end
   end

   assign room     = ((CNT_W+1)'(cnt_ff) + (CNT_W+1)'(1)) < (CNT_W+1)'(lim);
   assign lit_len  = lit_false_ff ? jkv_pkg::LIT_FALSE_LEN : jkv_pkg::LIT_TRUE_LEN;
   assign lit_ok   = (lit_idx_ff < lit_len) && (c == jkv_pkg::lit_char(lit_false_ff, lit_idx_ff));
   assign lit_last = (lit_idx_ff + 3'd1) == lit_len;

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         if (req_doc_end) begin
            phase_in = jkv_pkg::PH_KEY;
         end else begin
            unique case (phase_ff)
               jkv_pkg::PH_KEY: begin
                  if (key_hit) phase_in = jkv_pkg::PH_COLON;
               end
               jkv_pkg::PH_COLON: begin
                  if (c == jkv_pkg::CH_COLON) phase_in = jkv_pkg::PH_SPACE;
               end
               jkv_pkg::PH_SPACE: begin
                  if (!jkv_pkg::is_space(c)) begin
                     if (c == jkv_pkg::CH_QUOTE) begin
                        phase_in = jkv_pkg::PH_STRING;
                     end else if (jkv_pkg::is_digit(c) || c == jkv_pkg::CH_MINUS) begin
                        phase_in = room ? jkv_pkg::PH_NUMBER : jkv_pkg::PH_DONE;
                     end else if (c == jkv_pkg::CH_T || c == jkv_pkg::CH_F) begin
                        phase_in = jkv_pkg::PH_LITERAL;
                     end else begin
                        phase_in = jkv_pkg::PH_DONE;
                     end
                  end
               end
               jkv_pkg::PH_STRING: begin
                  if (c == jkv_pkg::CH_QUOTE) phase_in = jkv_pkg::PH_DONE;
               end
               jkv_pkg::PH_NUMBER: begin
                  if (!(jkv_pkg::is_num_char(c) && room)) phase_in = jkv_pkg::PH_DONE;
               end
               jkv_pkg::PH_LITERAL: begin
                  if (!lit_ok || lit_last) phase_in = jkv_pkg::PH_DONE;
               end
               jkv_pkg::PH_DONE: begin
                  phase_in = jkv_pkg::PH_DONE;
               end
               default: begin
                  phase_in = jkv_pkg::PH_KEY;
               end
            endcase
         end
      end
   end

   // Counters, status and queue entry
   always_comb begin
      cnt_in       = cnt_ff;
      lit_idx_in   = lit_idx_ff;
      lit_false_in = lit_false_ff;
      pending_in   = pending_ff;
      kind_in      = kind_ff;
      emit         = 1'b0;
      win_in       = win_ff;
      if (accept) begin
         unique case (phase_ff)
            jkv_pkg::PH_KEY: begin
               win_in[0] = c;
               for (int u = 1; u <= KEY_MAX; u++) begin
                  win_in[u] = win_ff[u-1];
               end
               if (key_hit) pending_in = jkv_pkg::OC_NOCOLON;
            end
            jkv_pkg::PH_COLON: begin
               if (c == jkv_pkg::CH_COLON) pending_in = jkv_pkg::OC_UNSUP;
            end
            jkv_pkg::PH_SPACE: begin
               if (!jkv_pkg::is_space(c)) begin
                  if (c == jkv_pkg::CH_QUOTE) begin
                     kind_in    = jkv_pkg::KIND_STRING;
                     pending_in = jkv_pkg::OC_NOQUOTE;
                  end else if (jkv_pkg::is_digit(c) || c == jkv_pkg::CH_MINUS) begin
                     kind_in    = jkv_pkg::KIND_NUMBER;
                     pending_in = jkv_pkg::OC_FOUND;
                     if (room) begin
                        emit   = 1'b1;
                        cnt_in = cnt_ff + CNT_W'(1);
                     end
                  end else if (c == jkv_pkg::CH_T || c == jkv_pkg::CH_F) begin
                     kind_in      = jkv_pkg::KIND_BOOL;
                     pending_in   = jkv_pkg::OC_UNSUP;
                     lit_false_in = (c == jkv_pkg::CH_F);
                     lit_idx_in   = 3'd1;
                     emit         = 1'b1;
                  end else begin
                     pending_in = jkv_pkg::OC_UNSUP;
                  end
               end
            end
            jkv_pkg::PH_STRING: begin
               if (c == jkv_pkg::CH_QUOTE) begin
                  pending_in = (cnt_ff >= lim) ? jkv_pkg::OC_TOOLONG : jkv_pkg::OC_FOUND;
               end else if (room) begin
                  emit   = 1'b1;
                  cnt_in = cnt_ff + CNT_W'(1);
               end else begin
                  // overflow: stop emitting, keep looking for the closing quote
                  cnt_in = lim;
               end
            end
            jkv_pkg::PH_NUMBER: begin
               if (jkv_pkg::is_num_char(c) && room) begin
                  emit   = 1'b1;
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
            jkv_pkg::PH_LITERAL: begin
               if (lit_ok) begin
                  emit       = {{CNT_W{1'b0}}, lit_idx_ff} < {3'b000, lim};
                  lit_idx_in = lit_idx_ff + 3'd1;
                  if (lit_last) pending_in = jkv_pkg::OC_FOUND;
               end else begin
                  pending_in = jkv_pkg::OC_UNSUP;
               end
            end
            jkv_pkg::PH_DONE: begin
               emit = 1'b0;
            end
            default: begin
               emit = 1'b0;
            end
         endcase
      end

      push                   = accept && (emit || req_doc_end);
      push_event.emit        = emit;
      push_event.value_byte  = c;
      push_event.kind        = kind_in;
      push_event.last        = req_doc_end;
      push_event.outcome     = pending_in;
      push_event.status_kind = (pending_in == jkv_pkg::OC_FOUND) ? kind_in
                                                                 : jkv_pkg::KIND_STRING;

      // Document end: drop back to the search for the key
      if (accept && req_doc_end) begin
         cnt_in       = '0;
         lit_idx_in   = 3'd0;
         lit_false_in = 1'b0;
         pending_in   = jkv_pkg::OC_NOKEY;
         kind_in      = jkv_pkg::KIND_STRING;
         for (int u = 0; u <= KEY_MAX; u++) begin
            win_in[u] = 8'h00;
         end
      end
   end

   always_ff @(posedge clock) begin
      exp_ff <= exp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_length_ff  <= jkv_pkg::KEY_LENGTH_RST;
         value_limit_ff <= jkv_pkg::VALUE_LIMIT_RST;
         for (int w = 0; w < jkv_pkg::KEY_WORDS; w++) begin
            key_bytes_ff[w] <= '0;
         end
         // hold input off until the aligned pattern catches up
         settle_ff      <= 1'b1;
         phase_ff       <= jkv_pkg::PH_KEY;
         cnt_ff         <= '0;
         lit_idx_ff     <= 3'd0;
         lit_false_ff   <= 1'b0;
         pending_ff     <= jkv_pkg::OC_NOKEY;
         kind_ff        <= jkv_pkg::KIND_STRING;
         for (int u = 0; u <= KEY_MAX; u++) begin
            win_ff[u] <= 8'h00;
         end
      end else begin
         settle_ff <= csr_write;
         if (csr_write) begin
            unique case (csr_index)
               jkv_pkg::CSR_KEY_LENGTH: begin
                  key_length_ff <= csr_wdata[jkv_pkg::KEY_REG_W-1:0];
               end
               jkv_pkg::CSR_KEY_BYTES_0: begin
                  key_bytes_ff[0] <= csr_wdata;
               end
               jkv_pkg::CSR_KEY_BYTES_1: begin
                  key_bytes_ff[1] <= csr_wdata;
               end
               jkv_pkg::CSR_KEY_BYTES_2: begin
                  key_bytes_ff[2] <= csr_wdata;
               end
               jkv_pkg::CSR_KEY_BYTES_3: begin
                  key_bytes_ff[3] <= csr_wdata;
               end
               jkv_pkg::CSR_VALUE_LIMIT: begin
                  value_limit_ff <= csr_wdata[jkv_pkg::LIMIT_W-1:0];
               end
               default: begin
                  value_limit_ff <= value_limit_ff;
               end
            endcase
         end
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         lit_idx_ff   <= lit_idx_in;
         lit_false_ff <= lit_false_in;
         pending_ff   <= pending_in;
         kind_ff      <= kind_in;
         win_ff       <= win_in;
      end
   end

endmodule

// ----- rtl/jkv_fifo.sv -----
// Small register queue of result entries between front and back end.
// Uses jkv_pkg::event_type; no other dependencies.
module jkv_fifo #(
   parameter int DEPTH = jkv_pkg::QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr,
   input  jkv_pkg::event_type wr_data,
   input  logic               rd,
   output jkv_pkg::event_type rd_data,
   output logic               empty,
   output logic               full
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   jkv_pkg::event_type mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      unique case ({wr, rd})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/jkv_back.sv -----
// Back end: splits each queue entry into its result transactions.
// Registered output stage on the rsp channel; uses jkv_pkg.
module jkv_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  jkv_pkg::event_type head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_value_byte,
   output logic               rsp_is_status,
   output logic [2:0]         rsp_outcome,
   output logic [1:0]         rsp_value_kind
);

   logic       rsp_valid_ff, rsp_valid_in;
   logic       sub_ff, sub_in;
   logic [7:0] byte_ff, byte_in;
   logic       status_ff, status_in;
   logic [2:0] outcome_ff, outcome_in;
   logic [1:0] kind_ff, kind_in;
   logic       load;

   // Output register is free when empty or being taken this cycle
   assign load = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      pop          = 1'b0;
      sub_in       = sub_ff;
      rsp_valid_in = rsp_valid_ff;
      byte_in      = byte_ff;
      status_in    = status_ff;
      outcome_in   = outcome_ff;
      kind_in      = kind_ff;
      if (load) begin
         rsp_valid_in = head_valid;
         if (head_valid) begin
            if (head.emit && !sub_ff) begin
               byte_in    = head.value_byte;
               status_in  = 1'b0;
               outcome_in = jkv_pkg::OC_FOUND;
               kind_in    = head.kind;
               // a status transaction still follows from the same entry
               if (head.last) begin
                  sub_in = 1'b1;
               end else begin
                  pop = 1'b1;
               end
            end else begin
               byte_in    = 8'h00;
               status_in  = 1'b1;
               outcome_in = head.outcome;
               kind_in    = head.status_kind;
               sub_in     = 1'b0;
               pop        = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      byte_ff    <= byte_in;
      status_ff  <= status_in;
      outcome_ff <= outcome_in;
      kind_ff    <= kind_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sub_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         sub_ff       <= sub_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value_byte = byte_ff;
   assign rsp_is_status  = status_ff;
   assign rsp_outcome    = outcome_ff;
   assign rsp_value_kind = kind_ff;

endmodule

// ----- rtl/json_key_value_extractor.sv -----
// Top level of the JSON key/value extractor: front end, result queue, back end.
// Depends on jkv_pkg, jkv_front, jkv_fifo and jkv_back.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | req_doc_byte, req_doc_end
//   rsp     | out       | rsp_valid / rsp_stall | rsp_value_byte, rsp_is_status,
//           |           |                       | rsp_outcome, rsp_value_kind
//   csr     | in        | csr_write             | csr_index, csr_wdata
//
// One document byte is accepted per cycle while req_stall is low; the key window
// compare and the phase machine settle each byte in that cycle.
// A byte that yields a value byte and the status transaction gives two rsp transactions, the value byte first.
// Reset is synchronous; req_stall is high for the cycle after reset and after each
// csr write while the aligned key pattern reloads.
// A queue of QUEUE_DEPTH entries takes up rsp_stall before req_stall rises.
module json_key_value_extractor #(
   parameter int KEY_MAX     = jkv_pkg::KEY_MAX_DEF,
   parameter int VALUE_MAX   = jkv_pkg::VALUE_MAX_DEF,
   parameter int QUEUE_DEPTH = jkv_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_doc_byte,
   input  logic                            req_doc_end,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [7:0]                      rsp_value_byte,
   output logic                            rsp_is_status,
   output logic [2:0]                      rsp_outcome,
   output logic [1:0]                      rsp_value_kind,
   input  logic                            csr_write,
   input  logic [jkv_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [jkv_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic               push;
   jkv_pkg::event_type push_event;
   logic               pop;
   jkv_pkg::event_type head;
   logic               queue_empty;
   logic               queue_full;

   jkv_front #(
      .KEY_MAX   (KEY_MAX),
      .VALUE_MAX (VALUE_MAX)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_doc_byte (req_doc_byte),
      .req_doc_end  (req_doc_end),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .queue_full   (queue_full),
      .push         (push),
      .push_event   (push_event)
   );

   jkv_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr      (push),
      .wr_data (push_event),
      .rd      (pop),
      .rd_data (head),
      .empty   (queue_empty),
      .full    (queue_full)
   );

   jkv_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (!queue_empty),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_value_byte (rsp_value_byte),
      .rsp_is_status  (rsp_is_status),
      .rsp_outcome    (rsp_outcome),
      .rsp_value_kind (rsp_value_kind)
   );

   // No byte may slip in while the key pattern reloads after a write
   property p_stall_after_csr;
      @(posedge clock) disable iff (reset)
         csr_write |=> req_stall;
   endproperty
   a_stall_after_csr: assert property (p_stall_after_csr)
      else $error("byte accepted right after a csr write");

   // Value transactions carry no outcome
   property p_value_clean;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_is_status |-> rsp_outcome == jkv_pkg::OC_FOUND;
   endproperty
   a_value_clean: assert property (p_value_clean)
      else $error("value transaction with nonzero outcome");

   // A failed status reports kind zero and no byte
   property p_fail_status;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_is_status && rsp_outcome != jkv_pkg::OC_FOUND |->
            rsp_value_kind == jkv_pkg::KIND_STRING && rsp_value_byte == 8'h00;
   endproperty
   a_fail_status: assert property (p_fail_status)
      else $error("failed status transaction carries kind or byte");

endmodule
